// ===== hdl/rbf_pkg.sv =====
// Shared types and constants of the RGB 3x3 box filter.
package rbf_pkg;

  localparam int DefaultMaxWidth = 256;
  localparam int OutQueueDepth = 4;

  // floor(s / 9) == (s * Div9Mul) >> Div9Shift for every nine-sample sum (s <= 2295)
  localparam logic [11:0] Div9Mul = 12'd3641;
  localparam int Div9Shift = 15;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

endpackage

// ===== hdl/rbf_out_queue.sv =====
// Output queue of the box filter: holds finished results until the receiver takes them.
module rbf_out_queue #(
  parameter int DEPTH = rbf_pkg::OutQueueDepth
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rbf_pkg::result_t           push_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output rbf_pkg::result_t           out_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [PW-1:0] LastSlot = PW'(DEPTH - 1);

  rbf_pkg::result_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    unique case ({push, pop})
      2'b10: begin
        count_nxt = count_r + CW'(1);
      end
      2'b01: begin
        count_nxt = count_r - CW'(1);
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LastSlot) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LastSlot) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/rgb_box_filter_3x3.sv =====
// Top level of the RGB 3x3 box filter: line memory, window, sums, divide by nine.
//
// Pixels of one frame enter in raster order on the in_ channel (in_action = 0).
// Each result is, per color, the floor of the mean of the 3x3 neighbourhood, with
// mirrored borders (the edge pixel is not repeated). Results trail the pixels by
// one row plus one pixel; after the last pixel send image_width + 1 drain requests
// (in_action = 1) to push out the rest. out_frame_end marks the last result.
// A request whose action does not fit the phase (drain inside a frame, pixel while
// draining) is taken and dropped.
// One request is accepted per clock while in_stall is low. A result reaches out_ from
// the request that completes it through memory read, then sums, then divide into the queue.
// The two line stores sit in one memory that is read when a request is accepted
// and written back in the following cycle; consecutive requests touch different columns.
// A four-entry output queue absorbs receiver stalls; in_stall rises only when four
// results are in flight or waiting. Writing either register restarts the frame.
// Reset restarts the frame with a 256 x 256 image; the line memory needs no clearing.
module rgb_box_filter_3x3 #(
  parameter int MAX_WIDTH = rbf_pkg::DefaultMaxWidth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_frame_end,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QD = rbf_pkg::OutQueueDepth;
  localparam int QCW = $clog2(QD + 1);
  localparam logic [8:0] WidthCap = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [8:0] WidthReset = (MAX_WIDTH < 256) ? 9'(MAX_WIDTH) : 9'd256;
  localparam logic [8:0] HeightCap = 9'd256;
  localparam logic [8:0] MinSize = 9'd3;

  typedef logic [2:0][23:0] column_t;   // rows top, middle, bottom; {r, g, b}

  function automatic column_t mirror_rows(input column_t c, input logic top_edge,
                                          input logic bot_edge);
    column_t m;
    m[0] = top_edge ? c[2] : c[0];
    m[1] = c[1];
    m[2] = bot_edge ? c[0] : c[2];
    return m;
  endfunction

  function automatic logic [11:0] sum9(input column_t a, input column_t b,
                                       input column_t c, input int ch);
    logic [11:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      s = s + 12'(a[i][ch*8 +: 8]) + 12'(b[i][ch*8 +: 8]) + 12'(c[i][ch*8 +: 8]);
    end
    return s;
  endfunction

  // configuration
  logic [8:0] width_r, height_r;
  logic [8:0] cfg_clamped, width_m1, height_m1, height_p1;

  // input position
  logic [8:0] in_row_r, in_col_r;
  logic [8:0] col_a, col_inc;
  logic       in_fire, draining, item_ok, pre_a, post_a, restart_a;

  // line memory: {row two above, row above} per column
  logic [47:0] line_mem [MAX_WIDTH];
  logic [47:0] rd_q_r;
  logic [AW-1:0] rd_addr;

  // stage 1
  logic          s1_valid_r, s1_pre_r, s1_post_r, s1_restart_r, s1_write_r, s1_drain_r;
  logic [23:0]   s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_emit;
  column_t       win1_r, win2_r, col_new, col_rt, col_lm, col_rm;
  logic [8:0]    out_row_r, out_col_r, out_col_inc;
  logic          top_edge, bot_edge;

  // stage 2
  logic             s2_valid_r, s2_fe_r;
  logic [2:0][11:0] s2_sum_r;
  logic [2:0][23:0] prod;
  rbf_pkg::result_t push_data, head;

  logic [QCW-1:0] q_count;
  logic [QCW:0]   pending;

  // ---------------------------------------------------------------- config
  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data < MinSize) begin
      cfg_clamped = MinSize;
    end
  end

  assign width_m1  = width_r - 9'd1;
  assign height_m1 = height_r - 9'd1;
  assign height_p1 = height_r + 9'd1;

  // ---------------------------------------------------------------- accept
  assign pending  = (QCW+1)'(s1_emit) + (QCW+1)'(s2_valid_r) + (QCW+1)'(q_count);
  assign in_stall = (pending >= (QCW+1)'(QD));
  assign in_fire  = in_valid && !in_stall;

  assign draining  = (in_row_r >= height_r);
  assign item_ok   = in_fire && (in_action == draining);
  assign col_a     = (in_col_r >= width_r) ? 9'd0 : in_col_r;
  assign col_inc   = col_a + 9'd1;
  assign restart_a = (in_row_r >= height_p1);
  assign pre_a     = (col_a == 9'd0) && (in_row_r >= 9'd2);
  assign post_a    = !restart_a && (col_a != 9'd0) && (in_row_r != 9'd0);
  assign rd_addr   = AW'(col_a);

  // ---------------------------------------------------------------- stage 1
  assign s1_emit = s1_valid_r && (s1_pre_r || s1_post_r);
  assign col_new = {(s1_drain_r ? 24'd0 : s1_pix_r), rd_q_r[23:0], rd_q_r[47:24]};

  assign top_edge    = (out_row_r == 9'd0);
  assign bot_edge    = (out_row_r == height_m1);
  assign out_col_inc = out_col_r + 9'd1;

  always_comb begin
    // left is the older window column, right the new one (or the old one at row start)
    col_rt = s1_post_r ? col_new : win2_r;
    col_lm = (out_col_r == 9'd0) ? col_rt : win1_r;
    col_rm = (out_col_r == width_m1) ? col_lm : col_rt;
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = {12'd0, s2_sum_r[k]} * {12'd0, rbf_pkg::Div9Mul};
    end
    push_data.red       = prod[2][rbf_pkg::Div9Shift +: 8];
    push_data.green     = prod[1][rbf_pkg::Div9Shift +: 8];
    push_data.blue      = prod[0][rbf_pkg::Div9Shift +: 8];
    push_data.frame_end = s2_fe_r;
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WidthReset;
      height_r     <= HeightCap;
      in_row_r     <= '0;
      in_col_r     <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      win1_r       <= '0;
      win2_r       <= '0;
    end else begin
      s1_valid_r <= item_ok;
      s2_valid_r <= s1_emit;

      priority if (cfg_we) begin
        unique case (rbf_pkg::cfg_index_t'(cfg_index))
          rbf_pkg::CFG_IMAGE_WIDTH: begin
            width_r <= (cfg_clamped > WidthCap) ? WidthCap : cfg_clamped;
          end
          rbf_pkg::CFG_IMAGE_HEIGHT: begin
            height_r <= (cfg_clamped > HeightCap) ? HeightCap : cfg_clamped;
          end
        endcase
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        win1_r    <= '0;
        win2_r    <= '0;
      end else begin
        // advance the input position
        if (item_ok) begin
          priority if (restart_a) begin
            in_row_r <= '0;
            in_col_r <= '0;
          end else if (col_inc >= width_r) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + 9'd1;
          end else begin
            in_col_r <= col_inc;
          end
        end

        // advance the output position, drop everything at frame end
        if (s1_valid_r) begin
          if (s1_restart_r) begin
            out_row_r <= '0;
            out_col_r <= '0;
            win1_r    <= '0;
            win2_r    <= '0;
          end else begin
            win1_r <= win2_r;
            win2_r <= col_new;
            if (s1_emit) begin
              if (out_col_inc >= width_r) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 9'd1;
              end else begin
                out_col_r <= out_col_inc;
              end
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (item_ok) begin
      s1_pre_r     <= pre_a;
      s1_post_r    <= post_a;
      s1_restart_r <= restart_a;
      s1_write_r   <= !draining;
      s1_drain_r   <= draining;
      s1_pix_r     <= {in_red_in, in_green_in, in_blue_in};
      s1_addr_r    <= rd_addr;
    end
    if (s1_emit) begin
      for (int k = 0; k < 3; k++) begin
        s2_sum_r[k] <= sum9(mirror_rows(col_lm, top_edge, bot_edge),
                            mirror_rows(win2_r, top_edge, bot_edge),
                            mirror_rows(col_rm, top_edge, bot_edge), k);
      end
      s2_fe_r <= bot_edge && (out_col_r == width_m1);
    end
  end

  // line memory: read on accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (item_ok) begin
      rd_q_r <= line_mem[rd_addr];
    end
    if (s1_valid_r && s1_write_r) begin
      line_mem[s1_addr_r] <= {rd_q_r[23:0], s1_pix_r};
    end
  end

  // ---------------------------------------------------------------- output
  rbf_out_queue #(
    .DEPTH(QD)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head),
    .count     (q_count)
  );

  assign out_red_out   = head.red;
  assign out_green_out = head.green;
  assign out_blue_out  = head.blue;
  assign out_frame_end = head.frame_end;

  // ---------------------------------------------------------------- checks
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_write_r && item_ok && !restart_a) |-> (s1_addr_r != rd_addr))
    else $error("line memory read hits the column being written back");

  a_results_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= (QCW+1)'(QD))
    else $error("more results in flight than the output queue can hold");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_restart_r && !cfg_we) |=>
      (out_row_r == 9'd0 && out_col_r == 9'd0 && in_row_r <= 9'd1))
    else $error("frame end did not return the output position to the origin");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_emit && bot_edge && out_col_r == width_m1 && !cfg_we) |=>
      (out_col_r == 9'd0))
    else $error("last result of a frame did not wrap the output column");

endmodule

// ===== tb/rbf_checker.sv =====
// Checker for the RGB 3x3 box filter: watches both channels, predicts each mean, compares.
`timescale 1ns / 100ps

module rbf_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_red_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_blue_out,
  input  logic       out_frame_end,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         checked_count,
  output int         frame_count
);

  localparam int LineLen = rbf_pkg::DefaultMaxWidth;
  localparam int MaxRows = 256;
  localparam int MinDim = 3;
  localparam int WindowTaps = 9;
  localparam int ShowLimit = 10;

  logic [23:0] upper_line [LineLen];
  logic [23:0] lower_line [LineLen];
  logic [23:0] win [3][3];
  logic [8:0]  row_in, col_in, row_out, col_out;
  logic [8:0]  width_reg, height_reg;
  rbf_pkg::result_t mean_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
    checked_count = 0;
    frame_count = 0;
  end

  function automatic int used_width();
    int w;
    w = width_reg;
    if (w < MinDim) w = MinDim;
    if (w > LineLen) w = LineLen;
    return w;
  endfunction

  function automatic int used_height();
    int h;
    h = height_reg;
    if (h < MinDim) h = MinDim;
    if (h > MaxRows) h = MaxRows;
    return h;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = '0;
      end
    end
    row_in = '0;
    col_in = '0;
    row_out = '0;
    col_out = '0;
  endfunction

  // Mean centred at (row_out, col_out); l, m, r pick window columns, borders mirror.
  function automatic void push_mean(input int l, input int m, input int r,
                                    input int w, input int h);
    int rows [3];
    int cols [3];
    int sum;
    logic [7:0] chan [3];
    rbf_pkg::result_t res;
    rows[0] = (row_out == 0) ? 2 : 0;
    rows[1] = 1;
    rows[2] = (row_out == h - 1) ? 0 : 2;
    if (col_out == 0) l = r;
    if (col_out == w - 1) r = l;
    cols[0] = l;
    cols[1] = m;
    cols[2] = r;
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          sum += int'(win[rows[i]][cols[j]][23 - 8 * k -: 8]);
        end
      end
      chan[k] = 8'(sum / WindowTaps);
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    res.frame_end = (row_out == h - 1) && (col_out == w - 1);
    mean_q.push_back(res);
    if (int'(col_out) + 1 >= w) begin
      col_out = '0;
      row_out = row_out + 9'd1;
    end else begin
      col_out = col_out + 9'd1;
    end
  endfunction

  function automatic void take_request(input logic drain_req, input logic [23:0] pix);
    int w, h, c, rr;
    logic draining;
    logic [23:0] top, mid, bot;
    w = used_width();
    h = used_height();
    c = col_in;
    rr = row_in;
    draining = (rr >= h);
    // drop requests that do not fit the phase
    if (drain_req != draining) return;
    if (c >= w) c = 0;
    // a new row finishes the last column of the row two above
    if (c == 0 && rr >= 2) push_mean(1, 2, 2, w, h);
    if (rr >= h + 1) begin
      restart_frame();
      return;
    end
    top = upper_line[c];
    mid = lower_line[c];
    bot = draining ? 24'h0 : pix;
    if (!draining) begin
      upper_line[c] = mid;
      lower_line[c] = pix;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    if (c >= 1 && rr >= 1) push_mean(0, 1, 2, w, h);
    c++;
    if (c >= w) begin
      c = 0;
      rr++;
    end
    col_in = 9'(c);
    row_in = 9'(rr);
  endfunction

  function automatic void check_result();
    rbf_pkg::result_t got, want;
    got.red = out_red_out;
    got.green = out_green_out;
    got.blue = out_blue_out;
    got.frame_end = out_frame_end;
    if (mean_q.size() == 0) begin
      fail_count++;
      if (fail_count <= ShowLimit)
        $display("%0t: result with nothing expected: r=%0d g=%0d b=%0d end=%0b",
                 $time, got.red, got.green, got.blue, got.frame_end);
      return;
    end
    want = mean_q.pop_front();
    checked_count++;
    if (got.frame_end === 1'b1) frame_count++;
    if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
        got.frame_end !== want.frame_end) begin
      fail_count++;
      if (fail_count <= ShowLimit)
        $display("%0t: mean mismatch: expected r=%0d g=%0d b=%0d end=%0b, %s%0d%s%0d%s%0d%s%0b",
                 $time, want.red, want.green, want.blue, want.frame_end,
                 "got r=", got.red, " g=", got.green, " b=", got.blue,
                 " end=", got.frame_end);
    end
  endfunction

  // Sample mid-cycle: everything driven at the rising edge is settled here and
  // holds until the edge that completes the handshake.
  always @(negedge clk) begin
    if (!rst_n) begin
      width_reg = 9'd256;
      height_reg = 9'd256;
      restart_frame();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_we) begin
        case (rbf_pkg::cfg_index_t'(cfg_index))
          rbf_pkg::CFG_IMAGE_WIDTH:  width_reg = cfg_data;
          rbf_pkg::CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
        restart_frame();
      end
      if (in_valid && !in_stall)
        take_request(in_action, {in_red_in, in_green_in, in_blue_in});
    end
    pending = mean_q.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the RGB 3x3 box filter testbench: clock, reset, pixel and drain stimulus, verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;
  localparam int RandomItems = 480;
  localparam int SettleCycles = 12;
  localparam int HoldCycles = 300;
  localparam int DimCap = 256;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = 1'b0;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red_out, out_green_out, out_blue_out;
  logic       out_frame_end;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  int fail_count, pending, checked_count, frame_count;

  // shared between the request and result sides
  bit         quiet = 1'b0;
  int         holds_asked = 0;
  int         holds_done = 0;
  logic [8:0] cur_w = 9'd256;
  logic [8:0] cur_h = 9'd256;
  int         stream_items = 0;
  int         stray_items = 0;

  rgb_box_filter_3x3 u_top (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_red_in, .in_green_in, .in_blue_in,
    .out_valid, .out_stall, .out_red_out, .out_green_out, .out_blue_out, .out_frame_end,
    .cfg_we, .cfg_index, .cfg_data
  );

  rbf_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_red_in, .in_green_in, .in_blue_in,
    .out_valid, .out_stall, .out_red_out, .out_green_out, .out_blue_out, .out_frame_end,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .checked_count, .frame_count
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic int clamp_dim(input logic [8:0] raw);
    if (raw < 3) return 3;
    if (raw > DimCap) return DimCap;
    return int'(raw);
  endfunction

  // Called right after a rising edge; returns right after the edge that took the request.
  task automatic send_req(input logic act, input logic [23:0] pix);
    int gap;
    logic took;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_red_in <= pix[23:16];
    in_green_in <= pix[15:8];
    in_blue_in <= pix[7:0];
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_size(input bit set_w, input bit set_h,
                              input logic [8:0] w, input logic [8:0] h);
    if (set_w) begin
      cfg_we <= 1'b1;
      cfg_index <= rbf_pkg::CFG_IMAGE_WIDTH;
      cfg_data <= w;
      cur_w = w;
      @(posedge clk);
    end
    if (set_h) begin
      cfg_we <= 1'b1;
      cfg_index <= rbf_pkg::CFG_IMAGE_HEIGHT;
      cfg_data <= h;
      cur_h = h;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // One frame of random pixels plus its drain; stop_at < 0 runs it to the end.
  task automatic run_frame(input int stop_at, input bit noisy, input int hold_at);
    int w, h, npix, total;
    w = clamp_dim(cur_w);
    h = clamp_dim(cur_h);
    npix = w * h;
    total = npix + w + 1;
    for (int n = 0; n < total; n++) begin
      if (n == stop_at) break;
      if (n == hold_at) holds_asked++;
      // out-of-phase request: drain inside the frame, pixel while draining
      if (noisy && $urandom_range(0, 24) == 0) begin
        send_req(n < npix ? ACT_DRAIN : ACT_PIXEL, rand_pixel());
        stray_items++;
      end
      send_req(n < npix ? ACT_PIXEL : ACT_DRAIN, rand_pixel());
      stream_items++;
    end
    if (noisy && stop_at < 0) begin
      repeat ($urandom_range(1, 2)) begin
        send_req(ACT_DRAIN, rand_pixel());
        stray_items++;
      end
    end
  endtask

  task automatic edge_frames();
    // registers below the floor, width written as zero and height as one; checkerboard of extremes
    program_size(1'b1, 1'b1, 9'd0, 9'd1);
    for (int p = 0; p < 9; p++) begin
      if (p == 4) begin
        send_req(ACT_DRAIN, 24'hFFFFFF);
        stray_items++;
      end
      send_req(ACT_PIXEL, (p == 4) ? 24'hFF00AA : ((p % 2) ? 24'h000000 : 24'hFFFFFF));
    end
    for (int d = 0; d < 4; d++) begin
      if (d == 3) begin
        send_req(ACT_PIXEL, 24'h5A5A5A);
        stray_items++;
      end
      send_req(ACT_DRAIN, 24'h000000);
    end
    send_req(ACT_DRAIN, 24'hFFFFFF);
    stray_items++;
    stream_items += 13;
    settle();
    // width only, every sample at full scale
    program_size(1'b1, 1'b0, 9'd2, 9'd0);
    for (int p = 0; p < 9; p++) send_req(ACT_PIXEL, 24'hFFFFFF);
    for (int d = 0; d < 4; d++) send_req(ACT_DRAIN, 24'hFFFFFF);
    stream_items += 13;
    settle();
  endtask

  initial begin
    int raw, stop_at, phase, base;
    bit set_w, set_h, cut_short;
    logic [8:0] nw, nh;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset size is 256 x 256: a partial frame, then abandon it with a write
    run_frame(300, 1'b0, -1);
    settle();
    edge_frames();

    // widest rows from all-ones write data, no idling; receiver holds off before
    // the first results so the queue fills and the input stalls
    quiet = 1'b1;
    program_size(1'b1, 1'b1, 9'd511, 9'd3);
    run_frame(300, 1'b0, 200);
    settle();
    quiet = 1'b0;

    base = stream_items;
    phase = 0;
    // the frame above was abandoned, so the first random phase writes a register
    cut_short = 1'b1;
    while (stream_items < base + RandomItems) begin
      set_w = ($urandom_range(0, 3) != 0);
      set_h = ($urandom_range(0, 3) != 0);
      if (cut_short && !set_w && !set_h) set_w = 1'b1;
      raw = $urandom_range(0, 19);
      if (raw == 0) nw = 9'($urandom_range(0, 2));
      else if (raw == 1) nw = 9'($urandom_range(17, 64));
      else nw = 9'($urandom_range(3, 12));
      nh = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(0, 2)) : 9'($urandom_range(3, 8));
      program_size(set_w, set_h, nw, nh);
      quiet = ($urandom_range(0, 3) == 0);
      cut_short = (phase != 3) && ($urandom_range(0, 6) == 0);
      stop_at = cut_short ? $urandom_range(1, clamp_dim(cur_w) * (clamp_dim(cur_h) + 1)) : -1;
      run_frame(stop_at, $urandom_range(0, 2) == 0, (phase == 3) ? 5 : -1);
      settle();
      phase++;
    end

    $display("Covered %0d frames and %0d checked means from %0d stream requests",
             frame_count, checked_count, stream_items);
    $display("(%0d out-of-phase requests dropped, %0d random frame phases, sizes 3 to 256).",
             stray_items, phase);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d means never arrived", fail_count, pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and long hold-offs on request.
  initial begin
    int len;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 35);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
      end
    end
  end

  // ~1300 requests plus hold-offs, taken many times over
  initial begin
    #12_000_000;
    $display("timeout with %0d means still expected", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
